// File: hdl/tpmq_pkg.sv
// ----------------------------------------------------------------------------
// tpmq_pkg
// shared types, constants and helpers of the tree path maximum query unit
// ----------------------------------------------------------------------------
`default_nettype none

package tpmq_pkg;

    // tree size and lifting depth
    localparam int MAX_NODES = 1024;
    localparam int LEVELS    = 10;

    // field widths
    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 16;
    localparam int TIME_W   = 11;
    localparam int COUNT_W  = 11;
    localparam int CMD_W    = 2;

    // table geometry: one row of MAX_NODES entries per level
    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int TBL_DEPTH = LEVELS * MAX_NODES;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    // configuration port
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0]   anc;
        logic [WEIGHT_W-1:0] wmax;
    } tbl_entry_t;

    typedef struct packed {
        logic [TIME_W-1:0] t_in;
        logic [TIME_W-1:0] t_out;
    } time_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B_ROOT,
        ST_B_RD1,
        ST_B_RD2,
        ST_B_WR,
        ST_Q_SWAP,
        ST_Q_T,
        ST_Q_X,
        ST_Q_F1,
        ST_Q_F2,
        ST_Q_OUT
    } state_t;

    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [NODE_W-1:0] nd);
        return TBL_AW'(lvl) * TBL_AW'(MAX_NODES) + TBL_AW'(nd);
    endfunction

    function automatic logic [WEIGHT_W-1:0] wmax(input logic [WEIGHT_W-1:0] a,
                                                input logic [WEIGHT_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // a is an ancestor of (or equal to) b
    function automatic logic is_above(input time_entry_t a, input time_entry_t b);
        return (a.t_in <= b.t_in) && (a.t_out >= b.t_out);
    endfunction

endpackage

`default_nettype wire

// File: hdl/tpmq_item_if.sv
// ----------------------------------------------------------------------------
// tpmq_item_if
// input item channel: valid/ready handshake with the command payload
// ----------------------------------------------------------------------------
`default_nettype none

interface tpmq_item_if
    import tpmq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [NODE_W-1:0]   node;
    logic [NODE_W-1:0]   parent;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [TIME_W-1:0]   enter_time;
    logic [TIME_W-1:0]   exit_time;
    logic [NODE_W-1:0]   other_node;

    modport source (
        output valid, cmd, node, parent, edge_weight, enter_time, exit_time, other_node,
        input  ready
    );

    modport sink (
        input  valid, cmd, node, parent, edge_weight, enter_time, exit_time, other_node,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/tpmq_result_if.sv
// ----------------------------------------------------------------------------
// tpmq_result_if
// result channel: valid/ready handshake with the path maximum
// ----------------------------------------------------------------------------
`default_nettype none

interface tpmq_result_if
    import tpmq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] path_max;

    modport source (
        output valid, path_max,
        input  ready
    );

    modport sink (
        input  valid, path_max,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/tpmq_ram.sv
// ----------------------------------------------------------------------------
// tpmq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tpmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/tree_path_max_query_unit.sv
// ----------------------------------------------------------------------------
// tree_path_max_query_unit
// binary lifting path maximum queries on a rooted tree held in two rams
// ----------------------------------------------------------------------------
// usage
//   item channel: one beat per command. cmd write stores a node record
//   (parent, edge weight, entry and exit time) into level 0; cmd build fills
//   levels 1 .. LEVELS-1 for node_count nodes; cmd query returns one result
//   beat with the largest edge weight on the path between node and other_node.
//   code 3 is taken and dropped. node_count is written over the apb port;
//   the user must write it only while the unit is idle; the unit does not check.
// timing
//   write: the next beat is taken in the following cycle
//   build: its length is set by the single read port of the table ram
//          (two reads per entry)
//   query: two table/time ram round trips per level and endpoint;
//          equal endpoints skip the lifting and answer 0
// reset
//   rst_n clears the sequencer, the result valid flag and sets node_count to 1;
//   ram contents are kept and are meaningless until written
// stall
//   the result waits in an output register; a new item is still taken, a
//   query only stops in its output state while the previous result is unread
// ----------------------------------------------------------------------------
`default_nettype none

module tree_path_max_query_unit
    import tpmq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    tpmq_item_if.sink          item,
    tpmq_result_if.source      result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  node_count_reg;
    logic                out_valid_reg, out_valid_next;
    logic [WEIGHT_W-1:0] out_data_reg;

    logic [LVL_W-1:0]    lvl_reg, lvl_next;       // current level
    logic [COUNT_W-1:0]  idx_reg, idx_next;       // build node index
    logic                phase_reg, phase_next;   // query: 0 lifts v, 1 lifts u
    logic [NODE_W-1:0]   cur_reg, cur_next;       // node being lifted
    logic [NODE_W-1:0]   u_reg, u_next;           // second endpoint
    logic [NODE_W-1:0]   v_reg, v_next;           // first endpoint after lifting
    logic [NODE_W-1:0]   up_reg, up_next;         // candidate ancestor
    logic [WEIGHT_W-1:0] w_reg, w_next;           // weight that goes with the step
    time_entry_t         fix_reg, fix_next;       // times of the fixed endpoint
    time_entry_t         tu_reg, tu_next;         // times of lifted u
    logic [WEIGHT_W-1:0] wu_reg, wu_next;         // level-0 weight of lifted u
    logic [WEIGHT_W-1:0] best_reg, best_next;     // running maximum
    logic [WEIGHT_W-1:0] res_reg, res_next;       // finished answer

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    logic              tbl_we;
    logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
    tbl_entry_t        tbl_wdata, tbl_rdata;
    logic              tim_we;
    logic [NODE_W-1:0] tim_waddr, tim_raddr;
    time_entry_t       tim_wdata, tim_rdata;

    // ancestor and path maximum per (level, node)
    tpmq_ram #(
        .WIDTH ($bits(tbl_entry_t)),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // dfs entry and exit times per node
    tpmq_ram #(
        .WIDTH ($bits(time_entry_t)),
        .DEPTH (MAX_NODES)
    ) u_tim_ram (
        .clk   (clk),
        .we    (tim_we),
        .waddr (tim_waddr),
        .wdata (tim_wdata),
        .raddr (tim_raddr),
        .rdata (tim_rdata)
    );

    // ------------------------------------------------------------------
    // shared combinational terms
    // ------------------------------------------------------------------
    logic               accept;
    logic               out_free;
    logic [COUNT_W-1:0] build_count;
    logic [COUNT_W-1:0] idx_inc;
    logic               idx_more;
    logic               last_lvl;
    logic               step_above;
    logic [NODE_W-1:0]  step_node;

    assign accept      = item.valid && item.ready;
    assign out_free    = !out_valid_reg || result.ready;
    // a build covers at most MAX_NODES nodes
    assign build_count = (node_count_reg > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES)
                                                                 : node_count_reg;
    assign idx_inc     = idx_reg + 1'b1;
    assign idx_more    = idx_inc < build_count;
    assign last_lvl    = lvl_reg == LVL_W'(LEVELS - 1);
    // the candidate ancestor sits above the fixed endpoint: stay put
    assign step_above  = is_above(tim_rdata, fix_reg);
    assign step_node   = step_above ? cur_reg : up_reg;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    priority if (item.cmd == CMD_BUILD)
                        state_next = ST_B_ROOT;
                    else if (item.cmd == CMD_QUERY)
                        state_next = (item.node == item.other_node) ? ST_Q_OUT : ST_Q_SWAP;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_B_ROOT:
            begin
                if (build_count == '0 || LEVELS == 1)
                    state_next = ST_IDLE;
                else
                    state_next = ST_B_RD1;
            end
            ST_B_RD1:  state_next = ST_B_RD2;
            ST_B_RD2:  state_next = ST_B_WR;
            ST_B_WR:
            begin
                priority if (idx_more)
                    state_next = ST_B_RD2;
                else if (!last_lvl)
                    state_next = ST_B_RD1;
                else
                    state_next = ST_IDLE;
            end
            ST_Q_SWAP: state_next = ST_Q_X;
            ST_Q_T:    state_next = ST_Q_X;
            ST_Q_X:
            begin
                priority if (lvl_reg != '0)
                    state_next = ST_Q_T;
                else if (!phase_reg)
                    state_next = ST_Q_SWAP;
                else
                    state_next = ST_Q_F1;
            end
            ST_Q_F1:   state_next = ST_Q_F2;
            ST_Q_F2:   state_next = ST_Q_OUT;
            ST_Q_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // memory controls and datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        item.ready     = 1'b0;
        tbl_we         = 1'b0;
        tbl_waddr      = '0;
        tbl_wdata      = '0;
        tbl_raddr      = '0;
        tim_we         = 1'b0;
        tim_waddr      = '0;
        tim_wdata      = '0;
        tim_raddr      = '0;
        out_valid_next = out_valid_reg && !result.ready;

        lvl_next   = lvl_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        cur_next   = cur_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        up_next    = up_reg;
        w_next     = w_reg;
        fix_next   = fix_reg;
        tu_next    = tu_reg;
        wu_next    = wu_reg;
        best_next  = best_reg;
        res_next   = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    priority if (item.cmd == CMD_WRITE)
                    begin
                        tbl_we          = 1'b1;
                        tbl_waddr       = tbl_addr('0, item.node);
                        tbl_wdata.anc   = item.parent;
                        tbl_wdata.wmax  = item.edge_weight;
                        tim_we          = 1'b1;
                        tim_waddr       = item.node;
                        tim_wdata.t_in  = item.enter_time;
                        tim_wdata.t_out = item.exit_time;
                    end
                    else if (item.cmd == CMD_BUILD)
                    begin
                        tbl_raddr = tbl_addr('0, '0);
                    end
                    else if (item.cmd == CMD_QUERY)
                    begin
                        tim_raddr  = item.other_node;
                        tbl_raddr  = tbl_addr(LVL_W'(LEVELS - 1), item.node);
                        cur_next   = item.node;
                        u_next     = item.other_node;
                        lvl_next   = LVL_W'(LEVELS - 1);
                        phase_next = 1'b0;
                        best_next  = '0;
                        res_next   = '0;
                    end
                    else
                    begin
                        tbl_raddr = '0;
                    end
                end
            end

            // root becomes its own level-0 ancestor, weight kept
            ST_B_ROOT:
            begin
                tbl_we         = 1'b1;
                tbl_waddr      = tbl_addr('0, '0);
                tbl_wdata.anc  = '0;
                tbl_wdata.wmax = tbl_rdata.wmax;
                lvl_next       = LVL_W'(1);
                idx_next       = '0;
            end

            ST_B_RD1:
            begin
                tbl_raddr = tbl_addr(lvl_reg - 1'b1, idx_reg[NODE_W-1:0]);
            end

            // first read back: fetch the entry of the midway ancestor
            ST_B_RD2:
            begin
                w_next    = tbl_rdata.wmax;
                tbl_raddr = tbl_addr(lvl_reg - 1'b1, tbl_rdata.anc);
            end

            // write one level up; the next read targets the lower level
            ST_B_WR:
            begin
                tbl_we         = 1'b1;
                tbl_waddr      = tbl_addr(lvl_reg, idx_reg[NODE_W-1:0]);
                tbl_wdata.anc  = tbl_rdata.anc;
                tbl_wdata.wmax = wmax(w_reg, tbl_rdata.wmax);
                priority if (idx_more)
                begin
                    idx_next  = idx_inc;
                    tbl_raddr = tbl_addr(lvl_reg - 1'b1, idx_inc[NODE_W-1:0]);
                end
                else if (!last_lvl)
                begin
                    idx_next = '0;
                    lvl_next = lvl_reg + 1'b1;
                end
                else
                begin
                    idx_next = '0;
                end
            end

            // time ram returns the fixed endpoint, table ram the top step
            ST_Q_SWAP:
            begin
                fix_next  = tim_rdata;
                up_next   = tbl_rdata.anc;
                w_next    = tbl_rdata.wmax;
                tim_raddr = tbl_rdata.anc;
            end

            ST_Q_T:
            begin
                up_next   = tbl_rdata.anc;
                w_next    = tbl_rdata.wmax;
                tim_raddr = tbl_rdata.anc;
            end

            // ancestor test, take the step when it stays below the other end
            ST_Q_X:
            begin
                if (!step_above)
                    best_next = wmax(best_reg, w_reg);
                priority if (lvl_reg != '0)
                begin
                    lvl_next  = lvl_reg - 1'b1;
                    cur_next  = step_node;
                    tbl_raddr = tbl_addr(lvl_reg - 1'b1, step_node);
                end
                else if (!phase_reg)
                begin
                    v_next     = step_node;
                    cur_next   = u_reg;
                    lvl_next   = LVL_W'(LEVELS - 1);
                    phase_next = 1'b1;
                    tim_raddr  = step_node;
                    tbl_raddr  = tbl_addr(LVL_W'(LEVELS - 1), u_reg);
                end
                else
                begin
                    cur_next  = step_node;
                    tim_raddr = step_node;
                    tbl_raddr = tbl_addr('0, step_node);
                end
            end

            ST_Q_F1:
            begin
                tu_next   = tim_rdata;
                wu_next   = tbl_rdata.wmax;
                tbl_raddr = tbl_addr('0, v_reg);
            end

            // final edge(s) next to the meeting point
            ST_Q_F2:
            begin
                priority if (is_above(tu_reg, fix_reg))
                    res_next = wmax(best_reg, tbl_rdata.wmax);
                else if (is_above(fix_reg, tu_reg))
                    res_next = wmax(best_reg, wu_reg);
                else
                    res_next = wmax(best_reg, wmax(wu_reg, tbl_rdata.wmax));
            end

            ST_Q_OUT:
            begin
                if (out_free)
                    out_valid_next = 1'b1;
            end

            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            node_count_reg <= NODE_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1] == REG_NODE_COUNT)
                node_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        lvl_reg   <= lvl_next;
        idx_reg   <= idx_next;
        phase_reg <= phase_next;
        cur_reg   <= cur_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        up_reg    <= up_next;
        w_reg     <= w_next;
        fix_reg   <= fix_next;
        tu_reg    <= tu_next;
        wu_reg    <= wu_next;
        best_reg  <= best_next;
        res_reg   <= res_next;
        if (state_reg == ST_Q_OUT && out_free)
            out_data_reg <= res_reg;
    end

    assign result.valid    = out_valid_reg;
    assign result.path_max = out_data_reg;

    // apb read side
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_NODE_COUNT) ? APB_DW'(node_count_reg) : '0;

endmodule

`default_nettype wire

// File: hdl/tpmq_checker.sv
// ----------------------------------------------------------------------------
// tpmq_checker
// port-level assertions for the tree path maximum query unit
// ----------------------------------------------------------------------------
`default_nettype none

module tpmq_checker
    import tpmq_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                item_valid,
    input wire logic                item_ready,
    input wire logic [CMD_W-1:0]    item_cmd,
    input wire logic                result_valid,
    input wire logic                result_ready,
    input wire logic [WEIGHT_W-1:0] result_path_max
);

    logic item_beat;
    assign item_beat = item_valid && item_ready;

    // a stalled result beat holds its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_path_max))
        else $error("result beat changed while stalled");

    // after a node record write the unit is ready again in the next cycle
    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        item_beat && item_cmd == CMD_WRITE |=> item_ready)
        else $error("unit busy after a record write");

    // build and query occupy the sequencer
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        item_beat && (item_cmd == CMD_BUILD || item_cmd == CMD_QUERY) |=> !item_ready)
        else $error("unit took a beat while a build or query ran");

    // a fresh result only comes out of a running query
    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_ready))
        else $error("result appeared while the unit was idle");

endmodule

bind tree_path_max_query_unit tpmq_checker u_tpmq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .item_cmd        (item.cmd),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_path_max (result.path_max)
);

`default_nettype wire

// File: tb/sv/tb_tree_path_max_query_unit.sv
// ----------------------------------------------------------------------------
// tb_tree_path_max_query_unit
// self-checking bench for the binary lifting path maximum query unit
// ----------------------------------------------------------------------------
// loads small random trees (plus one full size tree) as node records, builds
// the lifting tables and fires path queries between nodes of the loaded tree.
// a scoreboard keeps its own copy of the level tables and timestamps, works
// out each answer when the query beat is taken and compares it with the
// result beats in order. both channels idle at random, node_count is written
// and read back over apb while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tree_path_max_query_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tpmq_pkg::*;

    // command code the unit drops
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [PADDR_W-1:0] NODE_COUNT_ADDR = PADDR_W'(REG_NODE_COUNT) << 2;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_ITEMS = 2000;

    // ------------------------------------------------------------------------
    // scoreboard: mirror of the tables, expected answers in query order
    // ------------------------------------------------------------------------
    class lift_scoreboard;
        logic [NODE_W-1:0]   anc_tbl  [LEVELS][MAX_NODES];
        logic [WEIGHT_W-1:0] wmax_tbl [LEVELS][MAX_NODES];
        logic [TIME_W-1:0]   t_enter  [MAX_NODES];
        logic [TIME_W-1:0]   t_leave  [MAX_NODES];
        logic [COUNT_W-1:0]  node_count;
        logic [WEIGHT_W-1:0] pending_path_max [$];
        int mismatches = 0;
        int writes     = 0;
        int builds     = 0;
        int queries    = 0;
        int dropped    = 0;
        int checked    = 0;

        function new();
            foreach (anc_tbl[l, n])
            begin
                anc_tbl[l][n]  = '0;
                wmax_tbl[l][n] = '0;
            end
            foreach (t_enter[n])
            begin
                t_enter[n] = '0;
                t_leave[n] = '0;
            end
            node_count = NODE_COUNT_RESET;
        endfunction

        function logic [WEIGHT_W-1:0] heavier(logic [WEIGHT_W-1:0] a, logic [WEIGHT_W-1:0] b);
            return (a > b) ? a : b;
        endfunction

        // a sits on the root path of b (or is b)
        function bit covers(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
            return (t_enter[a] <= t_enter[b]) && (t_leave[a] >= t_leave[b]);
        endfunction

        function logic [WEIGHT_W-1:0] lifted_path_max(logic [NODE_W-1:0] v,
                                                      logic [NODE_W-1:0] u);
            logic [WEIGHT_W-1:0] best;
            logic [NODE_W-1:0]   up;
            best = '0;
            if (v == u)
                return '0;
            // lift v to just below the meeting point, then u
            for (int lvl = LEVELS - 1; lvl >= 0; lvl--)
            begin
                up = anc_tbl[lvl][v];
                if (!covers(up, u))
                begin
                    best = heavier(best, wmax_tbl[lvl][v]);
                    v    = up;
                end
            end
            for (int lvl = LEVELS - 1; lvl >= 0; lvl--)
            begin
                up = anc_tbl[lvl][u];
                if (!covers(up, v))
                begin
                    best = heavier(best, wmax_tbl[lvl][u]);
                    u    = up;
                end
            end
            if (covers(u, v))
                return heavier(best, wmax_tbl[0][v]);
            if (covers(v, u))
                return heavier(best, wmax_tbl[0][u]);
            return heavier(best, heavier(wmax_tbl[0][u], wmax_tbl[0][v]));
        endfunction

        function void note_item(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] node,
                                logic [NODE_W-1:0] parent, logic [WEIGHT_W-1:0] weight,
                                logic [TIME_W-1:0] t_in, logic [TIME_W-1:0] t_out,
                                logic [NODE_W-1:0] other);
            int count;
            logic [NODE_W-1:0] mid;
            case (cmd)
                CMD_WRITE:
                begin
                    anc_tbl[0][node]  = parent;
                    wmax_tbl[0][node] = weight;
                    t_enter[node]     = t_in;
                    t_leave[node]     = t_out;
                    writes++;
                end
                CMD_BUILD:
                begin
                    count = (int'(node_count) > MAX_NODES) ? MAX_NODES : int'(node_count);
                    anc_tbl[0][0] = '0;
                    for (int lvl = 1; lvl < LEVELS; lvl++)
                        for (int i = 0; i < count; i++)
                        begin
                            mid = anc_tbl[lvl - 1][i];
                            anc_tbl[lvl][i]  = anc_tbl[lvl - 1][mid];
                            wmax_tbl[lvl][i] = heavier(wmax_tbl[lvl - 1][i],
                                                       wmax_tbl[lvl - 1][mid]);
                        end
                    builds++;
                end
                CMD_QUERY:
                begin
                    pending_path_max.push_back(lifted_path_max(node, other));
                    queries++;
                end
                default:
                    dropped++;
            endcase
        endfunction

        function void check_path_max(logic [WEIGHT_W-1:0] actual);
            logic [WEIGHT_W-1:0] expected;
            if (pending_path_max.size() == 0)
            begin
                $display("%0t unexpected result beat: expected none, got path_max %0d",
                         $time, actual);
                mismatches++;
                return;
            end
            expected = pending_path_max.pop_front();
            checked++;
            if (expected !== actual)
            begin
                $display("%0t path_max mismatch: expected %0d, got %0d",
                         $time, expected, actual);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels, dut
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    tpmq_item_if   item_bus();
    tpmq_result_if result_bus();

    lift_scoreboard sb = new();

    // per item idling: a burst flag switches the random gaps off for a while
    bit src_burst  = 1'b0;
    bit sink_burst = 1'b0;

    // cycles the unit may still be busy after the last beat taken
    int busy_tail   = 4;
    int item_total  = 0;
    int cycle_count = 0;

    // tree being loaded: parent, preorder entry, last preorder in subtree
    int par       [MAX_NODES];
    int pre       [MAX_NODES];
    int last      [MAX_NODES];
    int span_size [MAX_NODES];
    int slot      [MAX_NODES];

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    tree_path_max_query_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one item beat; valid stays high afterwards unless a gap follows
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] node,
                             input logic [NODE_W-1:0] parent,
                             input logic [WEIGHT_W-1:0] weight,
                             input logic [TIME_W-1:0] t_in, input logic [TIME_W-1:0] t_out,
                             input logic [NODE_W-1:0] other);
        int gap;
        int cnt;
        gap = src_burst ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 63) == 0)
            src_burst = !src_burst;
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid       <= 1'b1;
        item_bus.cmd         <= cmd;
        item_bus.node        <= node;
        item_bus.parent      <= parent;
        item_bus.edge_weight <= weight;
        item_bus.enter_time  <= t_in;
        item_bus.exit_time   <= t_out;
        item_bus.other_node  <= other;
        do
            @(posedge clk);
        while (!item_bus.ready);
        sb.note_item(cmd, node, parent, weight, t_in, t_out, other);
        if (cmd != CMD_UNUSED)
            item_total++;
        // build length follows the count in force, saturated like the unit
        if (cmd == CMD_BUILD)
        begin
            cnt = (int'(sb.node_count) > MAX_NODES) ? MAX_NODES : int'(sb.node_count);
            busy_tail = 2 + 2 * cnt * (LEVELS - 1) + (LEVELS - 2) + 16;
        end
        else
            busy_tail = 4 * LEVELS + 8;
    endtask

    // query beat, unused fields filled with noise
    task automatic send_query(input int v, input int u);
        send_item(CMD_QUERY, NODE_W'(v), NODE_W'($urandom), WEIGHT_W'($urandom),
                  TIME_W'($urandom), TIME_W'($urandom), NODE_W'(u));
    endtask

    // wait for all answers, then for whatever work needs no answer
    task automatic settle();
        item_bus.valid <= 1'b0;
        while (sb.pending_path_max.size() != 0)
            @(posedge clk);
        repeat (busy_tail) @(posedge clk);
    endtask

    // apb write followed by a read back, only with the unit idle
    task automatic set_node_count(input int value);
        logic [APB_DW-1:0] readback;
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NODE_COUNT_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.node_count = COUNT_W'(value);
        // straight into the setup phase of the read
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== APB_DW'(value))
        begin
            $display("%0t node_count read back mismatch: expected %0d, got %0d",
                     $time, value, readback);
            sb.mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, check every beat taken
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        result_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
            begin
                sb.check_path_max(result_bus.path_max);
                stall_left = sink_burst ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 63) == 0)
                    sink_burst = !sink_burst;
            end
            else if (!result_bus.valid && !sink_burst && $urandom_range(0, 15) == 0)
                stall_left = $urandom_range(1, 15);
            result_bus.ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d answers still due",
                 cycle_count, sb.pending_path_max.size());
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int n;
        int phase;
        int style;
        int off;
        int lo;
        int wmode;
        int nq;
        int r;
        int v;
        int u;
        int stim_mark;
        int loads;
        logic [WEIGHT_W-1:0] w;

        // every input known from time zero
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        item_bus.valid       <= 1'b0;
        item_bus.cmd         <= CMD_WRITE;
        item_bus.node        <= '0;
        item_bus.parent      <= '0;
        item_bus.edge_weight <= '0;
        item_bus.enter_time  <= '0;
        item_bus.exit_time   <= '0;
        item_bus.other_node  <= '0;
        loads = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---

        // dropped code with every field at its top
        send_item(CMD_UNUSED, '1, '1, '1, '1, '1, '1);

        // zero count build: only the root ancestor is forced, no higher level is filled
        set_node_count(0);
        send_item(CMD_BUILD, '0, '0, '0, '0, '0, '0);

        // hand-made tree: 0 -> {1, 3}, 1 -> 2, 3 -> 4, times pushed up to 1024
        set_node_count(5);
        send_item(CMD_WRITE, 10'd0, 10'd0, 16'hFFFF, 11'd1020, 11'd1024, '0);
        send_item(CMD_WRITE, 10'd1, 10'd0, 16'hFFFF, 11'd1021, 11'd1022, '0);
        send_item(CMD_WRITE, 10'd2, 10'd1, 16'h0000, 11'd1022, 11'd1022, '0);
        send_item(CMD_WRITE, 10'd3, 10'd0, 16'd7,    11'd1023, 11'd1024, '0);
        send_item(CMD_WRITE, 10'd4, 10'd3, 16'd1,    11'd1024, 11'd1024, '0);
        send_item(CMD_BUILD, '1, '1, '1, '1, '1, '1);
        send_query(2, 4);
        send_query(4, 2);
        send_query(2, 2);
        send_query(0, 4);
        send_query(4, 0);
        send_query(1, 2);
        send_query(3, 3);
        send_query(2, 1);

        // stale tables: new level 0 record without a rebuild
        send_item(CMD_WRITE, 10'd4, 10'd3, 16'hFFFE, 11'd1024, 11'd1024, '0);
        send_query(4, 2);
        send_item(CMD_UNUSED, '0, '0, '0, '0, '0, '0);

        // --- random part: load a tree, build, query, with noise in between ---
        stim_mark = item_total;
        phase     = 0;
        while (item_total - stim_mark < RANDOM_ITEMS)
        begin
            // root only first, one full size tree, small trees otherwise
            if (phase == 0)
                n = 1;
            else if (phase == 2)
                n = MAX_NODES;
            else
                case ($urandom_range(0, 9))
                    0:       n = 1;
                    1:       n = $urandom_range(64, 200);
                    default: n = $urandom_range(2, 40);
                endcase
            set_node_count(n);

            // shape: chain, random parents, or parents close by (deep)
            style = $urandom_range(0, 2);
            par[0] = 0;
            for (int k = 1; k < n; k++)
                case (style)
                    0:       par[k] = k - 1;
                    1:       par[k] = $urandom_range(0, k - 1);
                    default:
                    begin
                        lo     = (k > 3) ? k - 3 : 0;
                        par[k] = $urandom_range(lo, k - 1);
                    end
                endcase

            // preorder timestamps from subtree sizes, children after parents
            for (int k = 0; k < n; k++)
                span_size[k] = 1;
            for (int k = n - 1; k > 0; k--)
                span_size[par[k]] += span_size[k];
            pre[0]  = 0;
            slot[0] = 1;
            for (int k = 1; k < n; k++)
            begin
                pre[k] = slot[par[k]];
                slot[par[k]] += span_size[k];
                slot[k] = pre[k] + 1;
            end
            off = $urandom_range(0, MAX_NODES + 1 - n);
            for (int k = 0; k < n; k++)
            begin
                last[k] = pre[k] + span_size[k] - 1 + off;
                pre[k]  = pre[k] + off;
            end

            // weights: full range, a few values with many ties, or extremes
            wmode = $urandom_range(0, 2);
            for (int k = 0; k < n; k++)
            begin
                case (wmode)
                    0:       w = WEIGHT_W'($urandom);
                    1:       w = WEIGHT_W'($urandom_range(0, 7));
                    default: w = ($urandom_range(0, 1) == 1) ? '1 : '0;
                endcase
                send_item(CMD_WRITE, NODE_W'(k), NODE_W'(par[k]), w, TIME_W'(pre[k]),
                          TIME_W'(last[k]), NODE_W'($urandom));
            end
            send_item(CMD_BUILD, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom),
                      TIME_W'($urandom), TIME_W'($urandom), NODE_W'($urandom));
            loads++;

            // full size tree again with a count past the table size
            if (n == MAX_NODES)
            begin
                set_node_count((1 << COUNT_W) - 1);
                send_item(CMD_BUILD, '0, '0, '0, '0, '0, '0);
            end

            nq = $urandom_range(10, 60);
            for (int j = 0; j < nq; j++)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    send_item(CMD_UNUSED, NODE_W'($urandom), NODE_W'($urandom),
                              WEIGHT_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
                              NODE_W'($urandom));
                else if (r < 12)
                    // rewrite a record with anything inside the loaded range
                    send_item(CMD_WRITE, NODE_W'($urandom_range(0, n - 1)),
                              NODE_W'($urandom_range(0, n - 1)), WEIGHT_W'($urandom),
                              TIME_W'($urandom), TIME_W'($urandom), NODE_W'($urandom));
                else if (r < 15)
                    send_item(CMD_BUILD, NODE_W'($urandom), NODE_W'($urandom),
                              WEIGHT_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
                              NODE_W'($urandom));
                else if (r < 17)
                begin
                    // zero count build in the middle of a tree, then restore
                    set_node_count(0);
                    send_item(CMD_BUILD, '0, '0, '0, '0, '0, '0);
                    set_node_count(n);
                end
                else
                begin
                    // a query in the first slot of a tree starts at its highest numbered node
                    v = (j == 0) ? n - 1 : $urandom_range(0, n - 1);
                    u = (r < 27) ? v : $urandom_range(0, n - 1);
                    send_query(v, u);
                end
            end
            phase++;
        end

        // --- drain and report ---
        settle();
        $display("ran %0d record writes, %0d table builds, %0d path queries, %0d dropped codes",
                 sb.writes, sb.builds, sb.queries, sb.dropped);
        $display("%0d random trees of 1 to %0d nodes, %0d answers checked in %0d cycles",
                 loads, MAX_NODES, sb.checked, cycle_count);
        if (sb.mismatches == 0 && sb.pending_path_max.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
